### rtl/core/sobel_edge_magnitude_rgb_top_defines.svh
// ----------------------------------------------------------------------------
// sobel edge magnitude assertion macros
// shared assertion helpers for the sobel core, clocked on clock, held off in reset
// ----------------------------------------------------------------------------
`ifndef SOBEL_EDGE_MAGNITUDE_RGB_TOP_DEFINES_SVH
`define SOBEL_EDGE_MAGNITUDE_RGB_TOP_DEFINES_SVH

// property must hold at every edge outside reset
`define SOBEL_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// condition must never be seen outside reset
`define SOBEL_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error(msg);

`endif

### rtl/core/sobel_pkg.sv
// ----------------------------------------------------------------------------
// sobel package
// shared widths, codes, kernel tables and helpers of the sobel edge core
// ----------------------------------------------------------------------------
`default_nettype none

package sobel_pkg;

   // default line store width
   localparam int MAX_WIDTH_DEF = 1024;
   localparam int HEIGHT_LIMIT  = 4096;

   // field and counter widths
   localparam int ROW_W     = 12;
   localparam int HGT_W     = 13;
   localparam int WREG_W    = 11;
   localparam int HREG_W    = 13;
   localparam int CH_W      = 8;
   localparam int PIX_W     = 24;
   localparam int SUM_W     = 11;
   localparam int ABS_W     = 10;
   localparam int SQ_W      = 2 * ABS_W;
   localparam int SSUM_W    = SQ_W + 1;
   localparam int ROOT_W    = 16;
   localparam int TAP_W     = 4;
   localparam int ITER_W    = 3;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int QUEUE_DEPTH = 2;

   // reset values of the registers
   localparam logic [WREG_W-1:0] WIDTH_RST  = 11'd640;
   localparam logic [HREG_W-1:0] HEIGHT_RST = 13'd480;

   // magnitude limits: above this sum of squares the rounded root exceeds 255
   localparam logic [SSUM_W-1:0] SAT_LIMIT  = 21'd65280;
   localparam logic [CH_W-1:0]   CH_MAX     = 8'd255;
   localparam logic [ROOT_W-1:0] ROOT_START = 16'h4000;
   localparam logic [ITER_W-1:0] ITER_LAST  = 3'd7;
   localparam logic [TAP_W-1:0]  TAP_END    = 4'd9;

   // item kinds
   typedef enum logic {
      REQ_PIXEL = 1'b0,
      REQ_FLUSH = 1'b1
   } req_kind_type;

   // register indexes
   typedef enum logic {
      REG_WIDTH  = 1'b0,
      REG_HEIGHT = 1'b1
   } reg_index_type;

   // kernel taps in raster order over the 3x3 window
   localparam logic signed [2:0] GX_TAB [9] = '{
      -3'sd1, 3'sd0, 3'sd1,
      -3'sd2, 3'sd0, 3'sd2,
      -3'sd1, 3'sd0, 3'sd1
   };
   localparam logic signed [2:0] GY_TAB [9] = '{
      -3'sd1, -3'sd2, -3'sd1,
       3'sd0,  3'sd0,  3'sd0,
       3'sd1,  3'sd2,  3'sd1
   };

   // flow status seen by the front end
   typedef struct packed {
      logic q_full;
      logic q_empty;
      logic back_busy;
   } flow_type;

   // one pixel channel times a kernel weight
   function automatic logic signed [SUM_W-1:0] sobel_term(
      input logic [CH_W-1:0]   v,
      input logic signed [2:0] k
   );
      logic signed [SUM_W-1:0] sv;
      logic signed [SUM_W-1:0] term;
      sv = $signed({{(SUM_W-CH_W){1'b0}}, v});
      unique case (k)
         3'sd1:   term = sv;
         -3'sd1:  term = -sv;
         3'sd2:   term = sv <<< 1;
         -3'sd2:  term = -(sv <<< 1);
         default: term = '0;
      endcase
      return term;
   endfunction

endpackage

`default_nettype wire

### rtl/core/sobel_edge_magnitude_rgb_top.sv
// ----------------------------------------------------------------------------
// sobel edge magnitude rgb top
// 3x3 sobel edge magnitude over an rgb raster stream with a register port
// ----------------------------------------------------------------------------
// req channel: one item per pixel in raster order (req_type pixel), or a
// flush item (req_type flush) that releases one pending output once the
// whole frame has arrived. rsp channel: one item per output pixel, each
// channel round(sqrt(gx^2+gy^2)) capped at 255, rsp_frame_end on the last.
// output k of a frame is released by pixel k+width+1; the last width+1
// outputs need flush items. pixels while draining and flushes before the
// frame is complete are taken and dropped.
// the back end walks the nine window taps over one line store read
// port, squares, then runs an 8-step integer root for each result.
// a pixel is taken only when the back end and the job queue are idle;
// flush items queue up to two jobs ahead.
// register writes (width at 0x0, height at 0x4) restart the frame.
// reset clears all position and handshake state; registers return to
// 640 x 480. a stalled rsp_ready holds the result and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module sobel_edge_magnitude_rgb_top #(
   parameter int MAX_WIDTH = sobel_pkg::MAX_WIDTH_DEF,
   localparam int COL_W = $clog2(MAX_WIDTH > 1 ? MAX_WIDTH : 2),
   localparam int WID_W = COL_W + 1,
   localparam int JOB_W = sobel_pkg::ROW_W + COL_W + 1
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_type,
   input  logic [sobel_pkg::CH_W-1:0]       req_red_in,
   input  logic [sobel_pkg::CH_W-1:0]       req_green_in,
   input  logic [sobel_pkg::CH_W-1:0]       req_blue_in,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [sobel_pkg::CH_W-1:0]       rsp_red_out,
   output logic [sobel_pkg::CH_W-1:0]       rsp_green_out,
   output logic [sobel_pkg::CH_W-1:0]       rsp_blue_out,
   output logic                             rsp_frame_end,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [sobel_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [sobel_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [sobel_pkg::CSR_DATA_W-1:0] prdata,
   output logic                             pready
);
   import sobel_pkg::*;

   logic [WREG_W-1:0] width_ff;
   logic [HREG_W-1:0] height_ff;
   logic [WID_W-1:0]  eff_width;
   logic [HGT_W-1:0]  eff_height;
   logic              csr_write;
   reg_index_type     reg_sel;

   logic              push;
   logic              pop;
   logic [JOB_W-1:0]  push_data;
   logic [JOB_W-1:0]  pop_data;
   logic              q_full;
   logic              q_empty;
   logic              back_busy;
   flow_type          flow;
   logic              wr_en;
   logic [COL_W+1:0]  wr_addr;
   logic [PIX_W-1:0]  wr_data;

   // register port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign reg_sel   = reg_index_type'(paddr[2]);

   always_comb begin
      unique case (reg_sel)
         REG_WIDTH:  prdata = CSR_DATA_W'(width_ff);
         REG_HEIGHT: prdata = CSR_DATA_W'(height_ff);
         default:    prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RST;
         height_ff <= HEIGHT_RST;
      end else if (csr_write) begin
         unique case (reg_sel)
            REG_WIDTH:  width_ff  <= pwdata[WREG_W-1:0];
            REG_HEIGHT: height_ff <= pwdata[HREG_W-1:0];
            default:    ;
         endcase
      end
   end

   // clamp the frame size to the supported range
   always_comb begin
      if (width_ff == '0) begin
         eff_width = WID_W'(1);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         eff_width = WID_W'(MAX_WIDTH);
      end else begin
         eff_width = WID_W'(width_ff);
      end
      if (height_ff == '0) begin
         eff_height = HGT_W'(1);
      end else if (32'(height_ff) > HEIGHT_LIMIT) begin
         eff_height = HGT_W'(HEIGHT_LIMIT);
      end else begin
         eff_height = HGT_W'(height_ff);
      end
   end

   assign flow = '{q_full: q_full, q_empty: q_empty, back_busy: back_busy};

   // front end
   sobel_front #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .restart      (csr_write),
      .width        (eff_width),
      .height       (eff_height),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_type     (req_type),
      .req_red_in   (req_red_in),
      .req_green_in (req_green_in),
      .req_blue_in  (req_blue_in),
      .flow         (flow),
      .push         (push),
      .push_data    (push_data),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data)
   );

   // job queue
   sobel_queue #(
      .DATA_W (JOB_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .full      (q_full),
      .empty     (q_empty)
   );

   // compute back end
   sobel_back #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .width         (eff_width),
      .height        (eff_height),
      .job_valid     (!q_empty),
      .job_data      (pop_data),
      .job_pop       (pop),
      .busy          (back_busy),
      .wr_en         (wr_en),
      .wr_addr       (wr_addr),
      .wr_data       (wr_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_red_out   (rsp_red_out),
      .rsp_green_out (rsp_green_out),
      .rsp_blue_out  (rsp_blue_out),
      .rsp_frame_end (rsp_frame_end)
   );

endmodule

`default_nettype wire

### rtl/core/sobel_queue.sv
// ----------------------------------------------------------------------------
// sobel job queue
// two-entry fifo of output jobs between the front end and the compute back end
// ----------------------------------------------------------------------------
`default_nettype none

module sobel_queue #(
   parameter int DATA_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   input  logic              pop,
   output logic [DATA_W-1:0] pop_data,
   output logic              full,
   output logic              empty
);
   import sobel_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [DATA_W-1:0] slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [CNT_W-1:0]  count_ff;

   assign full     = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = slot_ff[rd_ptr_ff];

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

endmodule

`default_nettype wire

### rtl/core/sobel_front.sv
// ----------------------------------------------------------------------------
// sobel front end
// accepts pixels and flush items, tracks frame position, writes the line
// store and queues one output job per released output
// ----------------------------------------------------------------------------
`default_nettype none

module sobel_front #(
   parameter int MAX_WIDTH = sobel_pkg::MAX_WIDTH_DEF,
   localparam int COL_W = $clog2(MAX_WIDTH > 1 ? MAX_WIDTH : 2),
   localparam int WID_W = COL_W + 1,
   localparam int JOB_W = sobel_pkg::ROW_W + COL_W + 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       restart,
   input  logic [WID_W-1:0]           width,
   input  logic [sobel_pkg::HGT_W-1:0] height,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_type,
   input  logic [sobel_pkg::CH_W-1:0] req_red_in,
   input  logic [sobel_pkg::CH_W-1:0] req_green_in,
   input  logic [sobel_pkg::CH_W-1:0] req_blue_in,
   input  sobel_pkg::flow_type        flow,
   output logic                       push,
   output logic [JOB_W-1:0]           push_data,
   output logic                       wr_en,
   output logic [COL_W+1:0]           wr_addr,
   output logic [sobel_pkg::PIX_W-1:0] wr_data
);
   import sobel_pkg::*;

   localparam int CNT_W = WID_W + 1;

   logic [COL_W-1:0] in_col_ff, in_col_in;
   logic [ROW_W-1:0] in_row_ff, in_row_in;
   logic [COL_W-1:0] out_col_ff, out_col_in;
   logic [ROW_W-1:0] out_row_ff, out_row_in;
   logic [CNT_W-1:0] lag_ff, lag_in;
   logic             drain_ff, drain_in;
   logic             accept;
   logic             out_col_end, out_row_end;
   logic             in_col_end, in_row_end;
   logic             release_out;
   logic             job_last;

   // pixels wait for an idle back end so the line store is never overwritten
   assign req_ready = !flow.q_full &&
                      ((req_type == REQ_FLUSH) || (flow.q_empty && !flow.back_busy));
   assign accept    = req_valid && req_ready;

   // frame position compares
   assign out_col_end = ({1'b0, out_col_ff} == (width - WID_W'(1)));
   assign out_row_end = ({1'b0, out_row_ff} == (height - HGT_W'(1)));
   assign in_col_end  = ({1'b0, in_col_ff} == (width - WID_W'(1)));
   assign in_row_end  = ({1'b0, in_row_ff} == (height - HGT_W'(1)));
   assign release_out = (lag_ff >= (CNT_W'(width) + CNT_W'(1)));

   // line store write and job payload
   assign wr_addr   = {in_row_ff[1:0], in_col_ff};
   assign wr_data   = {req_red_in, req_green_in, req_blue_in};
   assign push_data = {out_row_ff, out_col_ff, job_last};

   // next frame position
   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      lag_in     = lag_ff;
      drain_in   = drain_ff;
      push       = 1'b0;
      job_last   = 1'b0;
      wr_en      = 1'b0;
      if (restart) begin
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
         lag_in     = '0;
         drain_in   = 1'b0;
      end else if (accept) begin
         if (req_type == REQ_FLUSH) begin
            if (drain_ff) begin
               push     = 1'b1;
               job_last = out_col_end && out_row_end;
               if (job_last) begin
                  in_col_in  = '0;
                  in_row_in  = '0;
                  out_col_in = '0;
                  out_row_in = '0;
                  lag_in     = '0;
                  drain_in   = 1'b0;
               end else if (out_col_end) begin
                  out_col_in = '0;
                  out_row_in = out_row_ff + ROW_W'(1);
               end else begin
                  out_col_in = out_col_ff + COL_W'(1);
               end
            end
         end else if (!drain_ff) begin
            wr_en = 1'b1;
            // output trailing by one row plus one pixel is now complete
            if (release_out) begin
               push = 1'b1;
               if (out_col_end) begin
                  out_col_in = '0;
                  out_row_in = out_row_ff + ROW_W'(1);
               end else begin
                  out_col_in = out_col_ff + COL_W'(1);
               end
            end else begin
               lag_in = lag_ff + CNT_W'(1);
            end
            if (in_col_end && in_row_end) begin
               drain_in = 1'b1;
            end else if (in_col_end) begin
               in_col_in = '0;
               in_row_in = in_row_ff + ROW_W'(1);
            end else begin
               in_col_in = in_col_ff + COL_W'(1);
            end
         end
      end
   end

   // position registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         lag_ff     <= '0;
         drain_ff   <= 1'b0;
      end else begin
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         lag_ff     <= lag_in;
         drain_ff   <= drain_in;
      end
   end

endmodule

`default_nettype wire

### rtl/core/sobel_back.sv
// ----------------------------------------------------------------------------
// sobel back end
// owns the line store, gathers the 3x3 window of a job one tap a cycle,
// squares the sobel sums and takes a rounded integer root per channel
// ----------------------------------------------------------------------------
`default_nettype none

`include "sobel_edge_magnitude_rgb_top_defines.svh"

module sobel_back #(
   parameter int MAX_WIDTH = sobel_pkg::MAX_WIDTH_DEF,
   localparam int COL_W = $clog2(MAX_WIDTH > 1 ? MAX_WIDTH : 2),
   localparam int WID_W = COL_W + 1,
   localparam int JOB_W = sobel_pkg::ROW_W + COL_W + 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [WID_W-1:0]            width,
   input  logic [sobel_pkg::HGT_W-1:0] height,
   input  logic                        job_valid,
   input  logic [JOB_W-1:0]            job_data,
   output logic                        job_pop,
   output logic                        busy,
   input  logic                        wr_en,
   input  logic [COL_W+1:0]            wr_addr,
   input  logic [sobel_pkg::PIX_W-1:0] wr_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [sobel_pkg::CH_W-1:0]  rsp_red_out,
   output logic [sobel_pkg::CH_W-1:0]  rsp_green_out,
   output logic [sobel_pkg::CH_W-1:0]  rsp_blue_out,
   output logic                        rsp_frame_end
);
   import sobel_pkg::*;

   localparam int ADDR_W    = COL_W + 2;
   localparam int MEM_DEPTH = 4 << COL_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_SQUARE,
      ST_SUM,
      ST_ROOT,
      ST_OUT
   } state_type;

   state_type state_ff;

   // line store, four rows addressed by row mod 4
   logic [PIX_W-1:0] line_mem [MEM_DEPTH];
   logic [PIX_W-1:0] rd_data_ff;

   // job and window walk
   logic [ROW_W-1:0]  row_ff;
   logic [COL_W-1:0]  col_ff;
   logic              last_ff;
   logic [TAP_W-1:0]  tap_ff;
   logic [TAP_W-1:0]  tap_d_ff;
   logic [1:0]        m_ff;
   logic [1:0]        n_ff;
   logic              tap_v_ff;
   logic              rd_ok_d_ff;

   // per-channel arithmetic lanes
   logic signed [SUM_W-1:0] gx_ff [3];
   logic signed [SUM_W-1:0] gy_ff [3];
   logic [SQ_W-1:0]         sqx_ff [3];
   logic [SQ_W-1:0]         sqy_ff [3];
   logic                    sat_ff [3];
   logic [ROOT_W-1:0]       rem_ff [3];
   logic [ROOT_W-1:0]       res_ff [3];
   logic [ITER_W-1:0]       iter_ff;

   // output register
   logic            rsp_valid_ff;
   logic [CH_W-1:0] red_ff, green_ff, blue_ff;
   logic            frame_end_ff;

   logic [HGT_W-1:0]  rp, rm1;
   logic [WID_W-1:0]  cp, cm1;
   logic              tap_ok;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [CH_W-1:0]         pix_ch [3];
   logic signed [SUM_W-1:0] term_x [3];
   logic signed [SUM_W-1:0] term_y [3];
   logic [ABS_W-1:0]        ax [3];
   logic [ABS_W-1:0]        ay [3];
   logic [SSUM_W-1:0]       ssum [3];
   logic [ROOT_W-1:0]       bitv;
   logic [ROOT_W:0]         trial [3];
   logic [ROOT_W:0]         rnd [3];
   logic [CH_W-1:0]         mag [3];
   logic                    out_free;

   assign busy      = (state_ff != ST_IDLE);
   assign job_pop   = (state_ff == ST_IDLE) && job_valid;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // tap position and border check, rows and columns beyond the frame read as black
   always_comb begin
      rp      = HGT_W'(row_ff) + HGT_W'(m_ff);
      cp      = WID_W'(col_ff) + WID_W'(n_ff);
      rm1     = rp - HGT_W'(1);
      cm1     = cp - WID_W'(1);
      tap_ok  = (rp != '0) && (rp <= height) && (cp != '0) && (cp <= width);
      rd_addr = {rm1[1:0], cm1[COL_W-1:0]};
      rd_en   = (state_ff == ST_READ) && (tap_ff != TAP_END) && tap_ok;
   end

   // line store ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= line_mem[rd_addr];
      end
   end

   // per-channel datapath
   assign bitv = ROOT_START >> {iter_ff, 1'b0};

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         pix_ch[ch] = rd_ok_d_ff ? rd_data_ff[PIX_W-1-CH_W*ch -: CH_W] : '0;
         term_x[ch] = sobel_term(pix_ch[ch], GX_TAB[tap_d_ff]);
         term_y[ch] = sobel_term(pix_ch[ch], GY_TAB[tap_d_ff]);
         ax[ch]     = gx_ff[ch][SUM_W-1] ? ABS_W'(-gx_ff[ch]) : ABS_W'(gx_ff[ch]);
         ay[ch]     = gy_ff[ch][SUM_W-1] ? ABS_W'(-gy_ff[ch]) : ABS_W'(gy_ff[ch]);
         ssum[ch]   = {1'b0, sqx_ff[ch]} + {1'b0, sqy_ff[ch]};
         trial[ch]  = {1'b0, res_ff[ch]} + {1'b0, bitv};
         // round to nearest: step up when the remainder exceeds the root
         rnd[ch]    = {1'b0, res_ff[ch]} + (ROOT_W+1)'(rem_ff[ch] > res_ff[ch]);
         mag[ch]    = (sat_ff[ch] || (rnd[ch] > (ROOT_W+1)'(CH_MAX))) ? CH_MAX
                                                                    : rnd[ch][CH_W-1:0];
      end
   end

   // sequencer and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         tap_v_ff     <= 1'b0;
      end else begin
         tap_v_ff <= (state_ff == ST_READ) && (tap_ff != TAP_END);
         // the output state reloads the register itself when it is free
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end

         // window accumulation happens in the cycle after the read
         if (tap_v_ff) begin
            for (int ch = 0; ch < 3; ch++) begin
               gx_ff[ch] <= gx_ff[ch] + term_x[ch];
               gy_ff[ch] <= gy_ff[ch] + term_y[ch];
            end
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (job_valid) begin
                  {row_ff, col_ff, last_ff} <= job_data;
                  tap_ff <= '0;
                  m_ff   <= '0;
                  n_ff   <= '0;
                  for (int ch = 0; ch < 3; ch++) begin
                     gx_ff[ch] <= '0;
                     gy_ff[ch] <= '0;
                  end
                  state_ff <= ST_READ;
               end
            end
            ST_READ: begin
               if (tap_ff == TAP_END) begin
                  state_ff <= ST_SQUARE;
               end else begin
                  tap_d_ff   <= tap_ff;
                  rd_ok_d_ff <= tap_ok;
                  tap_ff     <= tap_ff + TAP_W'(1);
                  if (n_ff == 2'd2) begin
                     n_ff <= '0;
                     m_ff <= m_ff + 2'd1;
                  end else begin
                     n_ff <= n_ff + 2'd1;
                  end
               end
            end
            ST_SQUARE: begin
               for (int ch = 0; ch < 3; ch++) begin
                  sqx_ff[ch] <= ax[ch] * ax[ch];
                  sqy_ff[ch] <= ay[ch] * ay[ch];
               end
               state_ff <= ST_SUM;
            end
            ST_SUM: begin
               for (int ch = 0; ch < 3; ch++) begin
                  sat_ff[ch] <= (ssum[ch] > SAT_LIMIT);
                  rem_ff[ch] <= ssum[ch][ROOT_W-1:0];
                  res_ff[ch] <= '0;
               end
               iter_ff  <= '0;
               state_ff <= ST_ROOT;
            end
            ST_ROOT: begin
               // one result bit per cycle for all three channels
               for (int ch = 0; ch < 3; ch++) begin
                  if ({1'b0, rem_ff[ch]} >= trial[ch]) begin
                     rem_ff[ch] <= rem_ff[ch] - trial[ch][ROOT_W-1:0];
                     res_ff[ch] <= (res_ff[ch] >> 1) + bitv;
                  end else begin
                     res_ff[ch] <= res_ff[ch] >> 1;
                  end
               end
               iter_ff <= iter_ff + ITER_W'(1);
               if (iter_ff == ITER_LAST) begin
                  state_ff <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  red_ff       <= mag[0];
                  green_ff     <= mag[1];
                  blue_ff      <= mag[2];
                  frame_end_ff <= last_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_red_out   = red_ff;
   assign rsp_green_out = green_ff;
   assign rsp_blue_out  = blue_ff;
   assign rsp_frame_end = frame_end_ff;

   // checks
   `SOBEL_NEVER(a_no_write_during_job, wr_en && (state_ff != ST_IDLE), "line store written during job")
   `SOBEL_ASSERT(a_pop_starts_read, job_pop |=> (state_ff == ST_READ), "job pop did not start read")
   `SOBEL_ASSERT(a_out_loads, ((state_ff == ST_OUT) && out_free) |=> rsp_valid_ff, "result not loaded")

endmodule

`default_nettype wire

### sim/sobel_checker.sv
// ----------------------------------------------------------------------------
// sobel result checker
// watches the pixel and result channels, predicts each output pixel from its
// own copy of the line stores and frame counters, and compares in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sobel_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_type,
   input  logic [7:0]  req_red_in,
   input  logic [7:0]  req_green_in,
   input  logic [7:0]  req_blue_in,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [7:0]  rsp_red_out,
   input  logic [7:0]  rsp_green_out,
   input  logic [7:0]  rsp_blue_out,
   input  logic        rsp_frame_end,
   input  logic        cfg_write,
   input  logic        cfg_index,
   input  logic [31:0] cfg_value,
   output int          fail_count,
   output int          pending_count
);
   import sobel_pkg::*;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       last;
   } edge_pixel_type;

   edge_pixel_type edge_queue[$];
   logic [10:0] width_reg;
   logic [12:0] height_reg;
   logic [23:0] rows[4][1024];
   int in_col, in_row, out_col, out_row;
   bit draining;

   function automatic int eff_width();
      int w;
      w = width_reg;
      if (w < 1) w = 1;
      if (w > 1024) w = 1024;
      return w;
   endfunction

   function automatic int eff_height();
      int h;
      h = height_reg;
      if (h < 1) h = 1;
      if (h > 4096) h = 4096;
      return h;
   endfunction

   function automatic void restart();
      in_col = 0; in_row = 0; out_col = 0; out_row = 0;
      draining = 0;
   endfunction

   // rounded root of a sum of squares, capped at full scale
   function automatic logic [7:0] mag(int gx, int gy);
      int s, n;
      s = gx * gx + gy * gy;
      n = 0;
      while ((n + 1) * (n + 1) <= s) n++;
      if (s > n * n + n) n++;
      return n > 255 ? 8'd255 : n[7:0];
   endfunction

   function automatic edge_pixel_type predict_edge(bit last);
      edge_pixel_type e;
      int w, h, r, c, gx, gy, v, ch;
      logic [7:0] chans[3];
      w = eff_width(); h = eff_height();
      for (ch = 0; ch < 3; ch++) begin
         gx = 0; gy = 0;
         for (int m = 0; m < 3; m++) begin
            for (int n = 0; n < 3; n++) begin
               r = out_row + m - 1;
               c = out_col + n - 1;
               v = 0;
               if (r >= 0 && c >= 0 && r < h && c < w) v = (rows[r % 4][c] >> (16 - 8 * ch)) & 8'hff;
               gx += v * (n - 1) * (m == 1 ? 2 : 1);
               gy += v * (m - 1) * (n == 1 ? 2 : 1);
            end
         end
         chans[ch] = mag(gx, gy);
      end
      e.red = chans[0]; e.green = chans[1]; e.blue = chans[2]; e.last = last;
      return e;
   endfunction

   function automatic void advance_out();
      if (++out_col >= eff_width()) begin
         out_col = 0;
         out_row++;
      end
   endfunction

   function automatic void take_item(logic kind, logic [23:0] pix);
      int w, total, in_idx, out_idx;
      bit last;
      w = eff_width();
      total = w * eff_height();
      if (kind == REQ_FLUSH) begin
         if (!draining) return;
         out_idx = out_row * w + out_col;
         last = (out_idx + 1 >= total);
         edge_queue.push_back(predict_edge(last));
         if (last) restart();
         else advance_out();
         return;
      end
      if (draining) return;
      rows[in_row % 4][in_col] = pix;
      in_idx = in_row * w + in_col;
      out_idx = out_row * w + out_col;
      if (out_idx + w + 1 <= in_idx) begin
         edge_queue.push_back(predict_edge(0));
         advance_out();
      end
      if (in_idx + 1 >= total) draining = 1;
      else if (++in_col >= w) begin
         in_col = 0;
         in_row++;
      end
   endfunction

   // watch both channels and the register port
   always @(posedge clock) begin
      edge_pixel_type got, want;
      if (reset) begin
         width_reg = WIDTH_RST;
         height_reg = HEIGHT_RST;
         restart();
         edge_queue.delete();
         fail_count <= 0;
      end else begin
         if (cfg_write) begin
            if (cfg_index == REG_WIDTH) width_reg = cfg_value[10:0];
            else height_reg = cfg_value[12:0];
            restart();
         end
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_red_out, rsp_green_out, rsp_blue_out, rsp_frame_end};
            if (edge_queue.size() == 0) begin
               $display("%0t: unexpected item, actual %h", $time, got);
               fail_count <= fail_count + 1;
            end else begin
               want = edge_queue.pop_front();
               if (got !== want) begin
                  $display("%0t: mismatch, expected %h actual %h", $time, want, got);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_valid && req_ready)
            take_item(req_type, {req_red_in, req_green_in, req_blue_in});
      end
      pending_count <= edge_queue.size();
   end

endmodule

### sim/testbench.sv
// ----------------------------------------------------------------------------
// sobel edge magnitude testbench
// streams small rgb frames with flushes, noise and register changes through
// the core under random stalls; the checker predicts and compares results
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
   import sobel_pkg::*;

   logic clock, reset;
   logic req_valid, req_ready, req_type;
   logic [7:0] req_red_in, req_green_in, req_blue_in;
   logic rsp_valid, rsp_ready;
   logic [7:0] rsp_red_out, rsp_green_out, rsp_blue_out;
   logic rsp_frame_end;
   logic psel, penable, pwrite, pready;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [31:0] pwdata, prdata;
   int fail_count, pending_count;
   int sent;

   sobel_edge_magnitude_rgb_top dut (.*);

   sobel_checker checker_i (
      .clock, .reset, .req_valid, .req_ready, .req_type, .req_red_in,
      .req_green_in, .req_blue_in, .rsp_valid, .rsp_ready, .rsp_red_out,
      .rsp_green_out, .rsp_blue_out, .rsp_frame_end,
      .cfg_write(psel && penable && pwrite && pready),
      .cfg_index(reg_index_type'(paddr[2])), .cfg_value(pwdata),
      .fail_count, .pending_count
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #100ms;
      $display("Mismatches found");
      $finish;
   end

   // result side stalls at random
   initial begin
      rsp_ready = 0;
      forever begin
         @(negedge clock);
         rsp_ready = 1;
         @(posedge clock);
         while (!(rsp_valid && rsp_ready)) @(posedge clock);
         @(negedge clock);
         rsp_ready = 0;
         repeat ($urandom_range(0, 4)) @(negedge clock);
      end
   end

   task automatic send_item(logic kind, logic [7:0] r, logic [7:0] g, logic [7:0] b);
      int gap;
      gap = sent % 200 < 40 ? 0 : $urandom_range(0, 4);
      repeat (gap) @(negedge clock);
      req_valid = 1;
      req_type = kind;
      req_red_in = r; req_green_in = g; req_blue_in = b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      req_valid = 0;
      sent++;
   endtask

   task automatic send_random_pixel();
      send_item(REQ_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   task automatic write_reg(reg_index_type idx, logic [31:0] value);
      wait (pending_count == 0);
      repeat (60) @(negedge clock);
      psel <= 1; pwrite <= 1; penable <= 0;
      paddr <= {idx, 2'b00}; pwdata <= value;
      @(negedge clock);
      penable <= 1;
      @(negedge clock);
      psel <= 0; penable <= 0; pwrite <= 0;
   endtask

   // a frame's worth of items, stray flushes mixed in at random, then flushes and some stray items
   task automatic run_frame(int w, int h, bit extremes);
      int n;
      n = w * h;
      for (int i = 0; i < n; i++) begin
         if (extremes) send_item(REQ_PIXEL, i[0] ? 8'hff : 8'h00, i[1] ? 8'hff : 8'h00, 8'hff);
         else if ($urandom_range(0, 9) == 0)
            send_item(REQ_FLUSH, 8'($urandom), 8'($urandom), 8'($urandom));
         else send_random_pixel();
      end
      if ($urandom_range(0, 2) == 0) send_random_pixel();
      for (int i = 0; i < (n < w + 1 ? n : w + 1); i++) send_item(REQ_FLUSH, 8'd0, 8'd0, 8'd0);
      if ($urandom_range(0, 2) == 0) send_item(REQ_FLUSH, 8'd0, 8'd0, 8'd0);
   endtask

   initial begin
      int w, h;
      req_valid = 0; req_type = REQ_PIXEL;
      req_red_in = 0; req_green_in = 0; req_blue_in = 0;
      psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
      sent = 0;
      reset = 1;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 0;
      // directed: stray flush, tiny frames, saturating checkerboard, clamps
      send_item(REQ_FLUSH, 8'd0, 8'd0, 8'd0);
      write_reg(REG_WIDTH, 1); write_reg(REG_HEIGHT, 1);
      run_frame(1, 1, 1);
      write_reg(REG_WIDTH, 0); write_reg(REG_HEIGHT, 0);
      run_frame(1, 1, 0);
      write_reg(REG_WIDTH, 4); write_reg(REG_HEIGHT, 3);
      run_frame(4, 3, 1);
      // partial frame dropped by a write
      send_random_pixel(); send_random_pixel();
      write_reg(REG_WIDTH, 32'hffff_f805); write_reg(REG_HEIGHT, 32'hffff_e002);
      run_frame(5, 2, 0);
      // random frames, mostly small
      while (sent < 770) begin
         w = $urandom_range(1, 8); h = $urandom_range(1, 6);
         write_reg(REG_WIDTH, w); write_reg(REG_HEIGHT, h);
         run_frame(w, h, 0);
      end
      // clamped width and height on a partial frame that a write drops
      write_reg(REG_WIDTH, 2047); write_reg(REG_HEIGHT, 8191);
      for (int i = 0; i < 20; i++) send_random_pixel();
      wait (pending_count == 0);
      write_reg(REG_WIDTH, 640); write_reg(REG_HEIGHT, 480);
      wait (pending_count == 0);
      repeat (100) @(posedge clock);
      if (fail_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

### sobel_edge_magnitude_rgb_top.f
+incdir+rtl/core
rtl/core/sobel_pkg.sv
rtl/core/sobel_queue.sv
rtl/core/sobel_front.sv
rtl/core/sobel_back.sv
rtl/core/sobel_edge_magnitude_rgb_top.sv
sim/sobel_checker.sv
sim/testbench.sv
